FILE: hw/rtl/pscmp_pkg.sv
// Package: widths, control codes and shared types for the packed string compare core
`timescale 1ns / 1ps
package pscmp_pkg;

  localparam int unsigned HALF_W = 64;
  localparam int unsigned CTL_W  = 8;
  localparam int unsigned ELEMS  = 16;
  localparam int unsigned WORDS  = 8;
  localparam int unsigned ELEM_W = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned IDX_W  = 5;

  typedef enum logic [1:0] {
    AGG_EQUAL_ANY,
    AGG_RANGES,
    AGG_EQUAL_EACH,
    AGG_EQUAL_ORDERED
  } agg_t;

  typedef enum logic [1:0] {
    POL_POSITIVE,
    POL_NEGATIVE,
    POL_MASKED_POS,
    POL_MASKED_NEG
  } pol_t;

  typedef logic [ELEMS-1:0][ELEM_W-1:0] elem_vec_t;

  typedef struct packed {
    logic [HALF_W-1:0] data_low;
    logic [HALF_W-1:0] data_high;
    logic [HALF_W-1:0] pattern_low;
    logic [HALF_W-1:0] pattern_high;
    logic [CTL_W-1:0]  control_byte;
  } in_t;

  typedef struct packed {
    logic word;
    logic sgn;
    agg_t agg;
  } lane_ctl_t;

  typedef struct packed {
    logic [ELEMS-1:0] res1;
    logic [ELEMS-1:0] dvalid;
    logic             word;
    pol_t             pol;
    logic             msb;
    logic             zf;
    logic             sf;
  } mid_t;

  typedef struct packed {
    logic [IDX_W-1:0] match_index;
    logic             carry_flag;
    logic             zero_flag;
    logic             sign_flag;
    logic             overflow_flag;
  } result_t;

endpackage

FILE: hw/rtl/pscmp_in_if.sv
// Interface: input channel carrying one compare request per beat
`timescale 1ns / 1ps
interface pscmp_in_if;
  import pscmp_pkg::*;

  logic              valid;
  logic              ready;
  logic [HALF_W-1:0] data_low;
  logic [HALF_W-1:0] data_high;
  logic [HALF_W-1:0] pattern_low;
  logic [HALF_W-1:0] pattern_high;
  logic [CTL_W-1:0]  control_byte;

  modport source (
    output valid, data_low, data_high, pattern_low, pattern_high, control_byte,
    input  ready
  );
  modport sink (
    input  valid, data_low, data_high, pattern_low, pattern_high, control_byte,
    output ready
  );
endinterface

FILE: hw/rtl/pscmp_out_if.sv
// Interface: result channel carrying index and flags per beat
`timescale 1ns / 1ps
interface pscmp_out_if;
  import pscmp_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] match_index;
  logic             carry_flag;
  logic             zero_flag;
  logic             sign_flag;
  logic             overflow_flag;

  modport source (
    output valid, match_index, carry_flag, zero_flag, sign_flag, overflow_flag,
    input  ready
  );
  modport sink (
    input  valid, match_index, carry_flag, zero_flag, sign_flag, overflow_flag,
    output ready
  );
endinterface

FILE: hw/rtl/pscmp_lane.sv
// One compare lane: match bit for a single data element under all aggregations
`timescale 1ns / 1ps
module pscmp_lane #(
  parameter int unsigned LANE = 0
) (
  input  pscmp_pkg::elem_vec_t          d,
  input  pscmp_pkg::elem_vec_t          p,
  input  logic [pscmp_pkg::ELEMS-1:0]   dv,
  input  logic [pscmp_pkg::ELEMS-1:0]   pv,
  input  pscmp_pkg::lane_ctl_t          ctl,
  output logic                          match
);
  import pscmp_pkg::*;

  elem_vec_t         dsh;
  logic [ELEMS-1:0]  dvs;
  logic [ELEMS-1:0]  inr;
  logic [ELEMS-1:0]  allv;
  logic [ELEM_W-1:0] bias;
  logic [ELEM_W-1:0] db;
  logic [ELEM_W-1:0] lo;
  logic [ELEM_W-1:0] hi;
  logic              m_any;
  logic              m_rng;
  logic              m_each;
  logic              m_ord;

  always_comb begin
    // window of the data starting at this lane, for substring search
    dsh  = d >> (LANE * ELEM_W);
    dvs  = dv >> LANE;
    allv = ctl.word ? {{(ELEMS-WORDS){1'b0}}, {WORDS{1'b1}}} : {ELEMS{1'b1}};
    inr  = allv >> LANE;
    bias = ctl.sgn ? (ctl.word ? (ELEM_W'(1) << (ELEM_W-1)) : (ELEM_W'(1) << (BYTE_W-1)))
                   : '0;
    db   = d[LANE] ^ bias;
    lo   = '0;
    hi   = '0;

    m_any = 1'b0;
    for (int k = 0; k < ELEMS; k++) begin
      if (pv[k] && (d[LANE] == p[k])) m_any = 1'b1;
    end
    m_any = m_any & dv[LANE];

    m_rng = 1'b0;
    for (int j = 0; j < ELEMS/2; j++) begin
      lo = p[2*j] ^ bias;
      hi = p[2*j+1] ^ bias;
      if (pv[2*j+1] && (db >= lo) && (db <= hi)) m_rng = 1'b1;
    end
    m_rng = m_rng & dv[LANE];

    if (dv[LANE] && pv[LANE]) begin
      m_each = (d[LANE] == p[LANE]);
    end else begin
      m_each = !dv[LANE] && !pv[LANE];
    end

    m_ord = 1'b1;
    for (int k = 0; k < ELEMS; k++) begin
      if (inr[k] && pv[k] && !(dvs[k] && (dsh[k] == p[k]))) m_ord = 1'b0;
    end

    case (ctl.agg)
      AGG_EQUAL_ANY:  match = m_any;
      AGG_RANGES:     match = m_rng;
      AGG_EQUAL_EACH: match = m_each;
      default:        match = m_ord;
    endcase
  end

endmodule

FILE: hw/rtl/pscmp_merge.sv
// Merge stage: polarity, index search and flags from the lane match mask
`timescale 1ns / 1ps
module pscmp_merge (
  input  pscmp_pkg::mid_t    mid,
  output pscmp_pkg::result_t res
);
  import pscmp_pkg::*;

  logic [ELEMS-1:0] allmask;
  logic [ELEMS-1:0] res2;
  logic [IDX_W-1:0] idx;

  always_comb begin
    allmask = mid.word ? {{(ELEMS-WORDS){1'b0}}, {WORDS{1'b1}}} : {ELEMS{1'b1}};
    case (mid.pol)
      POL_NEGATIVE:   res2 = ~mid.res1 & allmask;
      POL_MASKED_NEG: res2 = (mid.res1 ^ mid.dvalid) & allmask;
      default:        res2 = mid.res1 & allmask;
    endcase

    idx = mid.word ? IDX_W'(WORDS) : IDX_W'(ELEMS);
    if (mid.msb) begin
      for (int i = 0; i < ELEMS; i++) begin
        if (res2[i]) idx = IDX_W'(i);
      end
    end else begin
      for (int i = ELEMS-1; i >= 0; i--) begin
        if (res2[i]) idx = IDX_W'(i);
      end
    end

    res.match_index   = idx;
    res.carry_flag    = |res2;
    res.zero_flag     = mid.zf;
    res.sign_flag     = mid.sf;
    res.overflow_flag = res2[0];
  end

endmodule

FILE: hw/rtl/packed_string_compare_index.sv
// Top level: packed string compare with index result, three-stage lane pipeline
`timescale 1ns / 1ps
// Implicit-length packed string compare returning a match index and CF/ZF/SF/OF.
// Three register stages: the input beat is captured, sixteen compare lanes (one
// per data element, eight active in word mode) produce the match mask, and the
// merge stage applies polarity and finds the index into the output register.
// A new beat is taken every cycle unless the output side stalls; a result passes the
// input, lane and output registers in turn and waits there while the output stalls.
module packed_string_compare_index_core (
  input  logic        clk,
  input  logic        rst_n,
  pscmp_in_if.sink    in_chan,
  pscmp_out_if.source out_chan
);
  import pscmp_pkg::*;

  logic             a_valid_r;
  in_t              a_r;
  logic             b_valid_r;
  mid_t             b_r;
  mid_t             b_nxt;
  logic             o_valid_r;
  result_t          o_r;
  result_t          o_nxt;
  logic             o_ready;
  logic             b_ready;
  logic             a_ready;
  logic [2*HALF_W-1:0] dcat;
  logic [2*HALF_W-1:0] pcat;
  elem_vec_t        d;
  elem_vec_t        p;
  logic [ELEMS-1:0] dv;
  logic [ELEMS-1:0] pv;
  logic             drun;
  logic             prun;
  lane_ctl_t        lctl;
  logic [ELEMS-1:0] lane_res;

  assign o_ready       = !o_valid_r || out_chan.ready;
  assign b_ready       = !b_valid_r || o_ready;
  assign a_ready       = !a_valid_r || b_ready;
  assign in_chan.ready = a_ready;

  // element split and implicit-length validity
  always_comb begin
    dcat = {a_r.data_high, a_r.data_low};
    pcat = {a_r.pattern_high, a_r.pattern_low};
    drun = 1'b1;
    prun = 1'b1;
    for (int i = 0; i < ELEMS; i++) begin
      if (a_r.control_byte[0]) begin
        d[i] = (i < WORDS) ? dcat[(i%WORDS)*ELEM_W +: ELEM_W] : '0;
        p[i] = (i < WORDS) ? pcat[(i%WORDS)*ELEM_W +: ELEM_W] : '0;
      end else begin
        d[i] = {{(ELEM_W-BYTE_W){1'b0}}, dcat[i*BYTE_W +: BYTE_W]};
        p[i] = {{(ELEM_W-BYTE_W){1'b0}}, pcat[i*BYTE_W +: BYTE_W]};
      end
      drun  = drun & (d[i] != '0) & (!a_r.control_byte[0] || (i < WORDS));
      prun  = prun & (p[i] != '0) & (!a_r.control_byte[0] || (i < WORDS));
      dv[i] = drun;
      pv[i] = prun;
    end
    lctl.word = a_r.control_byte[0];
    lctl.sgn  = a_r.control_byte[1];
    lctl.agg  = agg_t'(a_r.control_byte[3:2]);
  end

  for (genvar g = 0; g < ELEMS; g++) begin : g_lane
    pscmp_lane #(.LANE(g)) u_lane (
      .d     (d),
      .p     (p),
      .dv    (dv),
      .pv    (pv),
      .ctl   (lctl),
      .match (lane_res[g])
    );
  end

  always_comb begin
    b_nxt.res1   = lane_res;
    b_nxt.dvalid = dv;
    b_nxt.word   = a_r.control_byte[0];
    b_nxt.pol    = pol_t'(a_r.control_byte[5:4]);
    b_nxt.msb    = a_r.control_byte[6];
    b_nxt.zf     = a_r.control_byte[0] ? !dv[WORDS-1] : !dv[ELEMS-1];
    b_nxt.sf     = a_r.control_byte[0] ? !pv[WORDS-1] : !pv[ELEMS-1];
  end

  pscmp_merge u_merge (
    .mid (b_r),
    .res (o_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (a_ready) a_valid_r <= in_chan.valid;
      if (b_ready) b_valid_r <= a_valid_r;
      if (o_ready) o_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_chan.valid) begin
      a_r.data_low     <= in_chan.data_low;
      a_r.data_high    <= in_chan.data_high;
      a_r.pattern_low  <= in_chan.pattern_low;
      a_r.pattern_high <= in_chan.pattern_high;
      a_r.control_byte <= in_chan.control_byte;
    end
    if (b_ready && a_valid_r) b_r <= b_nxt;
    if (o_ready && b_valid_r) o_r <= o_nxt;
  end

  assign out_chan.valid         = o_valid_r;
  assign out_chan.match_index   = o_r.match_index;
  assign out_chan.carry_flag    = o_r.carry_flag;
  assign out_chan.zero_flag     = o_r.zero_flag;
  assign out_chan.sign_flag     = o_r.sign_flag;
  assign out_chan.overflow_flag = o_r.overflow_flag;

endmodule

FILE: test/testbench.sv
// Testbench: directed and random checks of the packed string compare core against a predictor
`timescale 1ns / 1ps
module testbench;
  import pscmp_pkg::*;

  localparam int unsigned STALL_CYCLES   = 300;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASE_ITEMS    = 642;
  localparam int unsigned DRAIN_CYCLES   = 12;

  logic clk;
  logic rst_n = 1'b0;

  logic    req_valid = 1'b0;
  in_t     req_beat = '0;
  logic    res_ready = 1'b0;

  pscmp_in_if  req_if ();
  pscmp_out_if res_if ();

  assign req_if.valid        = req_valid;
  assign req_if.data_low     = req_beat.data_low;
  assign req_if.data_high    = req_beat.data_high;
  assign req_if.pattern_low  = req_beat.pattern_low;
  assign req_if.pattern_high = req_beat.pattern_high;
  assign req_if.control_byte = req_beat.control_byte;
  assign res_if.ready        = res_ready;

  packed_string_compare_index_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if),
    .out_chan (res_if)
  );

  in_t         pending_reqs[$];
  result_t     expected_results[$];
  int unsigned send_idle_pct = 21;
  int unsigned recv_idle_pct = 55;
  logic        long_stall_req = 1'b0;
  int unsigned stall_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned error_count = 0;
  int unsigned beats_checked = 0;
  int unsigned match_beats = 0;
  int unsigned reqs_sent = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic elem_vec_t unpack_elems(input logic [127:0] s, input logic word_mode);
    elem_vec_t e;
    int i;
    e = '0;
    for (i = 0; i < ELEMS; i++) begin
      if (word_mode) begin
        if (i < WORDS) e[i] = s[i*ELEM_W +: ELEM_W];
      end else begin
        e[i] = {8'h00, s[i*BYTE_W +: BYTE_W]};
      end
    end
    return e;
  endfunction

  function automatic logic [127:0] pack_elems(input elem_vec_t e, input logic word_mode);
    logic [127:0] s;
    int i;
    s = '0;
    for (i = 0; i < ELEMS; i++) begin
      if (word_mode) begin
        if (i < WORDS) s[i*ELEM_W +: ELEM_W] = e[i];
      end else begin
        s[i*BYTE_W +: BYTE_W] = e[i][BYTE_W-1:0];
      end
    end
    return s;
  endfunction

  function automatic int implicit_length(input elem_vec_t e, input int count);
    int i, len;
    len = count;
    for (i = count - 1; i >= 0; i--)
      if (e[i] == '0) len = i;
    return len;
  endfunction

  function automatic result_t compare_strings(input in_t req);
    elem_vec_t   dv, pv;
    logic        word_mode, signed_mode, msb_mode, hit;
    agg_t        agg;
    pol_t        pol;
    int          count, dlen, plen, idx, i, k;
    logic [15:0] bias, db, lo_b, hi_b, full_mask, valid_mask, raw_mask, adj_mask;
    result_t     r;
    word_mode   = req.control_byte[0];
    signed_mode = req.control_byte[1];
    agg         = agg_t'(req.control_byte[3:2]);
    pol         = pol_t'(req.control_byte[5:4]);
    msb_mode    = req.control_byte[6];
    count       = word_mode ? WORDS : ELEMS;
    dv   = unpack_elems({req.data_high, req.data_low}, word_mode);
    pv   = unpack_elems({req.pattern_high, req.pattern_low}, word_mode);
    dlen = implicit_length(dv, count);
    plen = implicit_length(pv, count);
    bias      = signed_mode ? (word_mode ? 16'h8000 : 16'h0080) : 16'h0000;
    full_mask = word_mode ? 16'h00FF : 16'hFFFF;
    raw_mask  = '0;
    for (i = 0; i < count; i++) begin
      hit = 1'b0;
      case (agg)
        AGG_EQUAL_ANY: begin
          if (i < dlen)
            for (k = 0; k < plen; k++)
              if (dv[i] == pv[k]) hit = 1'b1;
        end
        AGG_RANGES: begin
          if (i < dlen) begin
            db = dv[i] ^ bias;
            for (k = 0; k + 1 < plen; k += 2) begin
              lo_b = pv[k] ^ bias;
              hi_b = pv[k+1] ^ bias;
              if (db >= lo_b && db <= hi_b) hit = 1'b1;
            end
          end
        end
        AGG_EQUAL_EACH: begin
          if (i < dlen && i < plen) hit = (dv[i] == pv[i]);
          else hit = (i >= dlen && i >= plen);
        end
        default: begin
          // substring must match from i on; pattern tail past the data end fails unless past the last element
          hit = 1'b1;
          for (k = 0; k < plen && i + k < count; k++)
            if (i + k >= dlen || dv[i+k] != pv[k]) hit = 1'b0;
        end
      endcase
      raw_mask[i] = hit;
    end
    valid_mask = 16'((32'd1 << dlen) - 32'd1) & full_mask;
    case (pol)
      POL_NEGATIVE:   adj_mask = ~raw_mask & full_mask;
      POL_MASKED_NEG: adj_mask = (raw_mask ^ valid_mask) & full_mask;
      default:        adj_mask = raw_mask & full_mask;
    endcase
    idx = count;
    if (msb_mode) begin
      for (i = 0; i < count; i++)
        if (adj_mask[i]) idx = i;
    end else begin
      for (i = count - 1; i >= 0; i--)
        if (adj_mask[i]) idx = i;
    end
    r.match_index   = IDX_W'(idx);
    r.carry_flag    = |adj_mask;
    r.zero_flag     = (dlen < count);
    r.sign_flag     = (plen < count);
    r.overflow_flag = adj_mask[0];
    return r;
  endfunction

  function automatic logic [7:0] ctl_of(input logic word_mode, input logic signed_mode,
                                        input agg_t agg, input pol_t pol, input logic msb_mode);
    return {1'b0, msb_mode, pol, agg, signed_mode, word_mode};
  endfunction

  function automatic logic [15:0] random_elem(input logic word_mode);
    logic [15:0] v;
    case ($urandom_range(3))
      0: v = 16'($urandom_range(1, 4));
      1: begin
        case ($urandom_range(3))
          0: v = 16'h7FFF;
          1: v = 16'h8000;
          2: v = 16'hFFFF;
          default: v = 16'h0001;
        endcase
        if (!word_mode) v = {8'h00, v[15:8] | v[7:0]};
      end
      default: v = 16'($urandom);
    endcase
    if (!word_mode) v[15:8] = 8'h00;
    return v;
  endfunction

  function automatic elem_vec_t random_string(input logic word_mode, input int count);
    elem_vec_t e;
    int len, i;
    e = '0;
    len = $urandom_range(count);
    for (i = 0; i < count; i++) begin
      if (i < len) begin
        e[i] = random_elem(word_mode);
        if (e[i] == '0) e[i] = 16'h0001;
      end else if (i > len && $urandom_range(1) == 1) begin
        e[i] = random_elem(word_mode);
      end
    end
    return e;
  endfunction

  function automatic in_t random_request();
    in_t         req;
    elem_vec_t   dv, pv;
    logic        word_mode;
    logic [15:0] tmp;
    int          count, start, k;
    req.control_byte = 8'($urandom);
    word_mode = req.control_byte[0];
    count = word_mode ? WORDS : ELEMS;
    if ($urandom_range(9) == 0) begin
      {req.data_high, req.data_low}       = {$urandom, $urandom, $urandom, $urandom};
      {req.pattern_high, req.pattern_low} = {$urandom, $urandom, $urandom, $urandom};
    end else begin
      dv = random_string(word_mode, count);
      pv = random_string(word_mode, count);
      case ($urandom_range(3))
        0: begin
          start = $urandom_range(count - 1);
          for (k = 0; k + start < count; k++)
            if ($urandom_range(4) != 0) pv[k] = dv[k+start];
        end
        1: begin
          for (k = 0; k + 1 < count; k += 2)
            if (pv[k] > pv[k+1]) begin
              tmp = pv[k];
              pv[k] = pv[k+1];
              pv[k+1] = tmp;
            end
        end
        2: begin
          pv = dv;
          if ($urandom_range(1) == 1) pv[$urandom_range(count - 1)] = random_elem(word_mode);
        end
        default: ;
      endcase
      {req.data_high, req.data_low}       = pack_elems(dv, word_mode);
      {req.pattern_high, req.pattern_low} = pack_elems(pv, word_mode);
    end
    return req;
  endfunction

  task automatic queue_req(input logic [127:0] data_str, input logic [127:0] pat_str,
                           input logic [7:0] ctl);
    in_t req;
    {req.data_high, req.data_low}       = data_str;
    {req.pattern_high, req.pattern_low} = pat_str;
    req.control_byte = ctl;
    pending_reqs.push_back(req);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at result %0d, %s: got %0d, expected %0d", beats_checked, what, got, want);
    error_count++;
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input logic with_stall);
    int unsigned n;
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    if (with_stall) long_stall_req = 1'b1;
    for (n = 0; n < PHASE_ITEMS; n++) pending_reqs.push_back(random_request());
    wait_drained();
  endtask

  // sender
  always @(posedge clk) begin : drive_requests
    in_t next_req;
    if (!rst_n) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_if.ready) begin
        expected_results.push_back(compare_strings(req_beat));
        reqs_sent++;
      end
      if (!req_valid || req_if.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = pending_reqs.pop_front();
          req_valid <= 1'b1;
          req_beat  <= next_req;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // long output hold-off
  always @(posedge clk) begin
    if (long_stall_req && stall_count < STALL_CYCLES) stall_count <= stall_count + 1;
  end

  always @(posedge clk) begin
    if (!rst_n) res_ready <= 1'b0;
    else res_ready <= !(long_stall_req && stall_count < STALL_CYCLES) &&
                      ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && res_if.valid && res_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with nothing outstanding", int'(res_if.match_index), 0);
      end else begin
        want = expected_results.pop_front();
        if (res_if.match_index !== want.match_index)
          report_mismatch("match_index", int'(res_if.match_index), int'(want.match_index));
        if (res_if.carry_flag !== want.carry_flag)
          report_mismatch("carry_flag", int'(res_if.carry_flag), int'(want.carry_flag));
        if (res_if.zero_flag !== want.zero_flag)
          report_mismatch("zero_flag", int'(res_if.zero_flag), int'(want.zero_flag));
        if (res_if.sign_flag !== want.sign_flag)
          report_mismatch("sign_flag", int'(res_if.sign_flag), int'(want.sign_flag));
        if (res_if.overflow_flag !== want.overflow_flag)
          report_mismatch("overflow_flag", int'(res_if.overflow_flag),
                          int'(want.overflow_flag));
        if (want.carry_flag) match_beats++;
      end
      beats_checked++;
    end
  end

  always @(posedge clk) begin
    if ((req_valid && req_if.ready) || (res_if.valid && res_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", quiet_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  localparam logic [127:0] TXT_ABCH   = 128'h6867_6665_6463_6261;
  localparam logic [127:0] TXT_FULL   = 128'h706F_6E6D_6C6B_6A69_6867_6665_6463_6261;
  localparam logic [127:0] ALL_ONES   = {128{1'b1}};

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    queue_req('0, '0, ctl_of(1'b0, 1'b0, AGG_EQUAL_ANY, POL_POSITIVE, 1'b0));
    queue_req(ALL_ONES, ALL_ONES, ctl_of(1'b0, 1'b0, AGG_EQUAL_ANY, POL_POSITIVE, 1'b0));
    queue_req(ALL_ONES, ALL_ONES, ctl_of(1'b0, 1'b0, AGG_RANGES, POL_POSITIVE, 1'b0));
    queue_req(ALL_ONES, ALL_ONES, ctl_of(1'b0, 1'b0, AGG_EQUAL_EACH, POL_POSITIVE, 1'b1));
    queue_req(ALL_ONES, ALL_ONES, 8'hFF);
    queue_req(TXT_ABCH, 128'h6563, ctl_of(1'b0, 1'b0, AGG_EQUAL_ANY, POL_POSITIVE, 1'b0));
    queue_req(TXT_ABCH, 128'h6563, ctl_of(1'b0, 1'b0, AGG_EQUAL_ANY, POL_NEGATIVE, 1'b0));
    queue_req(TXT_ABCH, 128'h6563, ctl_of(1'b0, 1'b0, AGG_EQUAL_ANY, POL_NEGATIVE, 1'b1));
    queue_req(TXT_ABCH, 128'h6563, ctl_of(1'b0, 1'b0, AGG_EQUAL_ANY, POL_MASKED_POS, 1'b1));
    queue_req(TXT_ABCH, 128'h6563, ctl_of(1'b0, 1'b0, AGG_EQUAL_ANY, POL_MASKED_NEG, 1'b1));
    queue_req(TXT_ABCH, 128'h6563,
              8'h80 | ctl_of(1'b0, 1'b0, AGG_EQUAL_ANY, POL_MASKED_NEG, 1'b0));
    queue_req(TXT_ABCH, 128'h6664, ctl_of(1'b0, 1'b0, AGG_RANGES, POL_POSITIVE, 1'b1));
    // odd-length pattern: the last pair loses its upper bound
    queue_req(TXT_ABCH, 128'h68_6466, ctl_of(1'b0, 1'b0, AGG_RANGES, POL_POSITIVE, 1'b1));
    queue_req(TXT_ABCH, 128'h61, ctl_of(1'b0, 1'b0, AGG_RANGES, POL_POSITIVE, 1'b0));
    queue_req(TXT_ABCH, 128'h7F80, ctl_of(1'b0, 1'b1, AGG_RANGES, POL_POSITIVE, 1'b1));
    queue_req(TXT_ABCH, 128'h7F80, ctl_of(1'b0, 1'b0, AGG_RANGES, POL_POSITIVE, 1'b1));
    queue_req(128'h8001_FFFF_7FFF, 128'h7FFF_8000,
              ctl_of(1'b1, 1'b1, AGG_RANGES, POL_POSITIVE, 1'b1));
    queue_req(TXT_ABCH, TXT_ABCH, ctl_of(1'b0, 1'b0, AGG_EQUAL_EACH, POL_NEGATIVE, 1'b0));
    queue_req(TXT_ABCH, 128'h6867_6678_6463_6261,
              ctl_of(1'b0, 1'b0, AGG_EQUAL_EACH, POL_NEGATIVE, 1'b0));
    queue_req('0, ALL_ONES, ctl_of(1'b0, 1'b0, AGG_EQUAL_EACH, POL_POSITIVE, 1'b0));
    queue_req(TXT_ABCH, 128'h65_6463,
              ctl_of(1'b0, 1'b0, AGG_EQUAL_ORDERED, POL_POSITIVE, 1'b0));
    queue_req(TXT_ABCH, 128'h7A68, ctl_of(1'b0, 1'b0, AGG_EQUAL_ORDERED, POL_POSITIVE, 1'b0));
    queue_req(TXT_FULL, 128'h7170, ctl_of(1'b0, 1'b0, AGG_EQUAL_ORDERED, POL_POSITIVE, 1'b0));
    queue_req(TXT_ABCH, '0, ctl_of(1'b0, 1'b0, AGG_EQUAL_ORDERED, POL_MASKED_NEG, 1'b1));
    queue_req(128'h0003_0002_0001_FFFF, 128'h0002,
              ctl_of(1'b1, 1'b0, AGG_EQUAL_ANY, POL_POSITIVE, 1'b0));
    queue_req(128'h0003_0002_0001_FFFF, 128'h0003_0002,
              ctl_of(1'b1, 1'b0, AGG_EQUAL_ORDERED, POL_POSITIVE, 1'b1));
    run_phase(21, 55, 1'b0);
    run_phase(55, 21, 1'b0);
    run_phase(0, 0, 1'b1);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d results from %0d requests, %0d of them with a match", beats_checked,
             reqs_sent, match_beats);
    $display("all aggregations and polarities in byte and word mode, random stalls on both sides");
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
